[sv/vrf_pkg.sv]
// vrf_pkg: shared types and constants for the video register file block
// holds register offsets, action codes and the result record
// no dependencies
`default_nettype none

package vrf_pkg;

    localparam int NUM_SPRITES_DEF = 8;

    localparam logic [8:0] LINES_PER_FRAME_RST = 9'd312;

    typedef enum logic [1:0]
    {
        ACT_READ  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_LINE  = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    // register offsets
    localparam logic [5:0] ADDR_SPR_LAST  = 6'h0F;
    localparam logic [5:0] ADDR_XPOS_HIGH = 6'h10;
    localparam logic [5:0] ADDR_CTRL_ONE  = 6'h11;
    localparam logic [5:0] ADDR_RASTER    = 6'h12;
    localparam logic [5:0] ADDR_PEN_X     = 6'h13;
    localparam logic [5:0] ADDR_PEN_Y     = 6'h14;
    localparam logic [5:0] ADDR_SPR_EN    = 6'h15;
    localparam logic [5:0] ADDR_CTRL_TWO  = 6'h16;
    localparam logic [5:0] ADDR_SPR_YEXP  = 6'h17;
    localparam logic [5:0] ADDR_MEM_PTR   = 6'h18;
    localparam logic [5:0] ADDR_IRQ_FLAG  = 6'h19;
    localparam logic [5:0] ADDR_IRQ_EN    = 6'h1A;
    localparam logic [5:0] ADDR_SPR_PRIO  = 6'h1B;
    localparam logic [5:0] ADDR_SPR_MC    = 6'h1C;
    localparam logic [5:0] ADDR_SPR_XEXP  = 6'h1D;
    localparam logic [5:0] ADDR_COLL_SS   = 6'h1E;
    localparam logic [5:0] ADDR_COLL_SB   = 6'h1F;
    localparam logic [5:0] ADDR_COL_FIRST = 6'h20;
    localparam logic [5:0] ADDR_COL_LAST  = 6'h2E;

    localparam int NUM_COLOURS = 15;

    localparam logic [7:0] CTRL_TWO_FILL = 8'hC0;
    localparam logic [7:0] MEM_PTR_FILL  = 8'h01;
    localparam logic [7:0] IRQ_FLAG_FILL = 8'h70;
    localparam logic [7:0] IRQ_EN_FILL   = 8'hF0;
    localparam logic [7:0] UNMAPPED_DATA = 8'hFF;

    // border and bad line limits
    localparam logic [9:0] FIRST_LINE_25 = 10'd51;
    localparam logic [9:0] FIRST_LINE_24 = 10'd55;
    localparam logic [9:0] LAST_LINE_25  = 10'd250;
    localparam logic [9:0] LAST_LINE_24  = 10'd246;
    localparam logic [9:0] BAD_LINE_LO   = 10'h030;
    localparam logic [9:0] BAD_LINE_HI   = 10'h0F7;

    typedef struct packed
    {
        logic       vertical_border;
        logic       bad_line_flag;
        logic [8:0] raster_line;
        logic       irq_out;
        logic [7:0] read_data;
    } result_t;

endpackage

`default_nettype wire

[sv/video_register_file_raster_irq.sv]
// video_register_file_raster_irq: register file and raster interrupt of a video controller
// uses vrf_pkg for offsets, action codes and the result record
// single module, state updated at request accept, results through a two-entry output buffer
`default_nettype none

// One request per clock while s_axis_tready is high. Every request (read, write
// or new raster line) is decoded against the register state in the cycle it is
// accepted; the state and a two-entry output buffer (output register plus skid
// register) update at that edge. The result goes to the output register and is
// offered on m_axis the next cycle, or to the skid register while a result waits,
// so a request can still be taken; s_axis_tready only drops when both entries are
// full. A lines_per_frame write applies from the next line event.
module video_register_file_raster_irq #(
    parameter int NUM_SPRITES = vrf_pkg::NUM_SPRITES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        cfg_wr_en,
    input  wire logic [8:0]  cfg_wr_data,     // lines_per_frame

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,    // reg_addr[5:0], write_data[13:6], zero fill
    input  wire logic [1:0]  s_axis_tuser,    // action[1:0]

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata     // read_data[7:0], irq_out[8], raster_line[17:9],
                                              // bad_line_flag[18], vertical_border[19], zero fill
);

    logic [8:0] lines_per_frame_reg;

    logic [7:0] sprite_x_reg [NUM_SPRITES];
    logic [7:0] sprite_y_reg [NUM_SPRITES];
    logic [7:0] sprite_x_next [NUM_SPRITES];
    logic [7:0] sprite_y_next [NUM_SPRITES];
    logic [3:0] colour_reg [vrf_pkg::NUM_COLOURS];
    logic [3:0] colour_next [vrf_pkg::NUM_COLOURS];

    logic [7:0] xpos_high_reg, xpos_high_next;
    logic [7:0] ctrl_one_reg, ctrl_one_next;
    logic [7:0] ctrl_two_reg, ctrl_two_next;
    logic [7:0] mem_ptr_reg, mem_ptr_next;
    logic [7:0] spr_en_reg, spr_en_next;
    logic [7:0] spr_yexp_reg, spr_yexp_next;
    logic [7:0] spr_prio_reg, spr_prio_next;
    logic [7:0] spr_mc_reg, spr_mc_next;
    logic [7:0] spr_xexp_reg, spr_xexp_next;
    logic [3:0] irq_flag_reg, irq_flag_next;
    logic [3:0] irq_en_reg, irq_en_next;
    logic [8:0] raster_cmp_reg, raster_cmp_next;
    logic       protect_reg, protect_next;
    logic [8:0] line_reg, line_next;
    logic       border_reg, border_next;
    logic       bad_line_reg, bad_line_next;

    vrf_pkg::result_t out_reg, skid_reg, result;
    logic             out_valid_reg, skid_valid_reg;

    vrf_pkg::action_t action;
    logic [5:0]       addr;
    logic [7:0]       wdata;
    logic             accept;
    logic             take;
    logic [7:0]       rdata;
    logic             irq_now;
    logic [9:0]       next_line;
    logic [9:0]       border_top_line;
    logic [9:0]       border_bottom_line;

    assign action = vrf_pkg::action_t'(s_axis_tuser);
    assign addr   = s_axis_tdata[5:0];
    assign wdata  = s_axis_tdata[13:6];

    assign s_axis_tready = !skid_valid_reg;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign take          = out_valid_reg && m_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, out_reg};

    assign irq_now            = |(irq_flag_reg & irq_en_reg);
    assign next_line          = {1'b0, line_reg} + 10'd1;
    assign border_top_line    = ctrl_one_reg[3] ? vrf_pkg::FIRST_LINE_25
                                                : vrf_pkg::FIRST_LINE_24;
    assign border_bottom_line = ctrl_one_reg[3] ? vrf_pkg::LAST_LINE_25
                                                : vrf_pkg::LAST_LINE_24;

    // read path
    always_comb
    begin
        rdata = vrf_pkg::UNMAPPED_DATA;
        if (addr <= vrf_pkg::ADDR_SPR_LAST)
        begin
            for (int i = 0; i < NUM_SPRITES; i++)
            begin
                if (addr[3:1] == 3'(i))
                begin
                    rdata = addr[0] ? sprite_y_reg[i] : sprite_x_reg[i];
                end
            end
        end
        else if (addr inside {[vrf_pkg::ADDR_COL_FIRST:vrf_pkg::ADDR_COL_LAST]})
        begin
            for (int i = 0; i < vrf_pkg::NUM_COLOURS; i++)
            begin
                if (addr[3:0] == 4'(i))
                begin
                    rdata = {4'b0000, colour_reg[i]};
                end
            end
        end
        else
        begin
            case (addr)
                vrf_pkg::ADDR_XPOS_HIGH: rdata = xpos_high_reg;
                vrf_pkg::ADDR_CTRL_ONE:  rdata = ctrl_one_reg;
                vrf_pkg::ADDR_RASTER:    rdata = line_reg[7:0];
                vrf_pkg::ADDR_PEN_X,
                vrf_pkg::ADDR_PEN_Y,
                vrf_pkg::ADDR_COLL_SS,
                vrf_pkg::ADDR_COLL_SB:   rdata = 8'h00;
                vrf_pkg::ADDR_SPR_EN:    rdata = spr_en_reg;
                vrf_pkg::ADDR_CTRL_TWO:  rdata = ctrl_two_reg | vrf_pkg::CTRL_TWO_FILL;
                vrf_pkg::ADDR_SPR_YEXP:  rdata = spr_yexp_reg;
                vrf_pkg::ADDR_MEM_PTR:   rdata = mem_ptr_reg | vrf_pkg::MEM_PTR_FILL;
                vrf_pkg::ADDR_IRQ_FLAG:  rdata = {irq_now, 3'b000, irq_flag_reg}
                                                 | vrf_pkg::IRQ_FLAG_FILL;
                vrf_pkg::ADDR_IRQ_EN:    rdata = {4'b0000, irq_en_reg} | vrf_pkg::IRQ_EN_FILL;
                vrf_pkg::ADDR_SPR_PRIO:  rdata = spr_prio_reg;
                vrf_pkg::ADDR_SPR_MC:    rdata = spr_mc_reg;
                vrf_pkg::ADDR_SPR_XEXP:  rdata = spr_xexp_reg;
                default:                 rdata = vrf_pkg::UNMAPPED_DATA;
            endcase
        end
    end

    // state update for one request
    always_comb
    begin
        sprite_x_next   = sprite_x_reg;
        sprite_y_next   = sprite_y_reg;
        colour_next     = colour_reg;
        xpos_high_next  = xpos_high_reg;
        ctrl_one_next   = ctrl_one_reg;
        ctrl_two_next   = ctrl_two_reg;
        mem_ptr_next    = mem_ptr_reg;
        spr_en_next     = spr_en_reg;
        spr_yexp_next   = spr_yexp_reg;
        spr_prio_next   = spr_prio_reg;
        spr_mc_next     = spr_mc_reg;
        spr_xexp_next   = spr_xexp_reg;
        irq_flag_next   = irq_flag_reg;
        irq_en_next     = irq_en_reg;
        raster_cmp_next = raster_cmp_reg;
        protect_next    = protect_reg;
        line_next       = line_reg;
        border_next     = border_reg;
        bad_line_next   = bad_line_reg;

        case (action)
            vrf_pkg::ACT_WRITE:
            begin
                if (addr <= vrf_pkg::ADDR_SPR_LAST)
                begin
                    for (int i = 0; i < NUM_SPRITES; i++)
                    begin
                        if (addr[3:1] == 3'(i))
                        begin
                            if (addr[0])
                            begin
                                sprite_y_next[i] = wdata;
                            end
                            else
                            begin
                                sprite_x_next[i] = wdata;
                            end
                        end
                    end
                end
                else if (addr inside {[vrf_pkg::ADDR_COL_FIRST:vrf_pkg::ADDR_COL_LAST]})
                begin
                    for (int i = 0; i < vrf_pkg::NUM_COLOURS; i++)
                    begin
                        if (addr[3:0] == 4'(i))
                        begin
                            colour_next[i] = wdata[3:0];
                        end
                    end
                end
                else
                begin
                    case (addr)
                        vrf_pkg::ADDR_XPOS_HIGH: xpos_high_next = wdata;
                        vrf_pkg::ADDR_CTRL_ONE:
                        begin
                            ctrl_one_next      = wdata;
                            raster_cmp_next[8] = wdata[7];
                        end
                        vrf_pkg::ADDR_RASTER:    raster_cmp_next[7:0] = wdata;
                        vrf_pkg::ADDR_SPR_EN:    spr_en_next = wdata;
                        vrf_pkg::ADDR_CTRL_TWO:  ctrl_two_next = wdata;
                        vrf_pkg::ADDR_SPR_YEXP:  spr_yexp_next = wdata;
                        vrf_pkg::ADDR_MEM_PTR:   mem_ptr_next = wdata;
                        vrf_pkg::ADDR_IRQ_FLAG:  irq_flag_next = wdata[3:0];
                        vrf_pkg::ADDR_IRQ_EN:    irq_en_next = wdata[3:0];
                        vrf_pkg::ADDR_SPR_PRIO:  spr_prio_next = wdata;
                        vrf_pkg::ADDR_SPR_MC:    spr_mc_next = wdata;
                        vrf_pkg::ADDR_SPR_XEXP:  spr_xexp_next = wdata;
                        vrf_pkg::ADDR_COLL_SS:   irq_flag_next[1] = 1'b0;
                        vrf_pkg::ADDR_COLL_SB:   irq_flag_next[2] = 1'b0;
                        default:                 ;
                    endcase
                    // compare check after a compare value write
                    if ((addr == vrf_pkg::ADDR_CTRL_ONE || addr == vrf_pkg::ADDR_RASTER)
                        && !protect_reg && !irq_flag_reg[0] && raster_cmp_next == line_reg)
                    begin
                        irq_flag_next[0] = 1'b1;
                        protect_next     = 1'b1;
                    end
                end
            end
            vrf_pkg::ACT_LINE:
            begin
                protect_next = irq_flag_reg[0];
                if (!irq_flag_reg[0] && {1'b0, raster_cmp_reg} == next_line)
                begin
                    irq_flag_next[0] = 1'b1;
                    protect_next     = 1'b1;
                end
                if (next_line == border_top_line && ctrl_one_reg[4])
                begin
                    border_next = 1'b0;
                end
                if (next_line == border_bottom_line)
                begin
                    border_next = 1'b1;
                end
                bad_line_next = (next_line >= vrf_pkg::BAD_LINE_LO)
                                && (next_line <= vrf_pkg::BAD_LINE_HI)
                                && (next_line[2:0] == ctrl_one_reg[2:0]);
                if (next_line >= {1'b0, lines_per_frame_reg})
                begin
                    line_next = 9'd0;
                end
                else
                begin
                    line_next = next_line[8:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        result.read_data       = (action == vrf_pkg::ACT_READ) ? rdata : 8'h00;
        result.irq_out         = |(irq_flag_next & irq_en_next);
        result.raster_line     = line_next;
        result.bad_line_flag   = bad_line_next;
        result.vertical_border = border_next;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lines_per_frame_reg <= vrf_pkg::LINES_PER_FRAME_RST;
            for (int i = 0; i < NUM_SPRITES; i++)
            begin
                sprite_x_reg[i] <= 8'h00;
                sprite_y_reg[i] <= 8'h00;
            end
            for (int i = 0; i < vrf_pkg::NUM_COLOURS; i++)
            begin
                colour_reg[i] <= 4'h0;
            end
            xpos_high_reg  <= 8'h00;
            ctrl_one_reg   <= 8'h00;
            ctrl_two_reg   <= 8'h00;
            mem_ptr_reg    <= 8'h00;
            spr_en_reg     <= 8'h00;
            spr_yexp_reg   <= 8'h00;
            spr_prio_reg   <= 8'h00;
            spr_mc_reg     <= 8'h00;
            spr_xexp_reg   <= 8'h00;
            irq_flag_reg   <= 4'h0;
            irq_en_reg     <= 4'h0;
            raster_cmp_reg <= 9'd0;
            protect_reg    <= 1'b0;
            line_reg       <= 9'd0;
            border_reg     <= 1'b0;
            bad_line_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                lines_per_frame_reg <= cfg_wr_data;
            end
            if (accept)
            begin
                sprite_x_reg   <= sprite_x_next;
                sprite_y_reg   <= sprite_y_next;
                colour_reg     <= colour_next;
                xpos_high_reg  <= xpos_high_next;
                ctrl_one_reg   <= ctrl_one_next;
                ctrl_two_reg   <= ctrl_two_next;
                mem_ptr_reg    <= mem_ptr_next;
                spr_en_reg     <= spr_en_next;
                spr_yexp_reg   <= spr_yexp_next;
                spr_prio_reg   <= spr_prio_next;
                spr_mc_reg     <= spr_mc_next;
                spr_xexp_reg   <= spr_xexp_next;
                irq_flag_reg   <= irq_flag_next;
                irq_en_reg     <= irq_en_next;
                raster_cmp_reg <= raster_cmp_next;
                protect_reg    <= protect_next;
                line_reg       <= line_next;
                border_reg     <= border_next;
                bad_line_reg   <= bad_line_next;
            end
            // output buffer occupancy
            if (take)
            begin
                if (skid_valid_reg)
                begin
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= accept;
                end
            end
            else if (accept)
            begin
                if (out_valid_reg)
                begin
                    skid_valid_reg <= 1'b1;
                end
                else
                begin
                    out_valid_reg <= 1'b1;
                end
            end
        end
    end

    // output buffer payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (accept)
            begin
                out_reg <= result;
            end
        end
        else if (accept)
        begin
            if (out_valid_reg)
            begin
                skid_reg <= result;
            end
            else
            begin
                out_reg <= result;
            end
        end
    end

endmodule

`default_nettype wire

[tb/video_register_file_raster_irq_test.sv]
`timescale 1ns / 1ps
// video_register_file_raster_irq_test: self-checking bench for the video register file
// predicts every result from its own register and raster model, checks each field in order
// depends on vrf_pkg and video_register_file_raster_irq

module video_register_file_raster_irq_test;

    localparam logic [5:0] ADDR_SPR0_X  = 6'h00;
    localparam logic [5:0] ADDR_TOP     = 6'h3F;
    localparam int         SPRITES      = vrf_pkg::NUM_SPRITES_DEF;
    localparam int         DRAIN_CYCLES = 4;
    localparam int         CYCLE_LIMIT  = 200000;
    localparam int         PHASES       = 6;
    localparam int         PHASE_ITEMS  = 200;

    class raster_regs_scoreboard;
        logic [8:0] spr_x[8];
        logic [7:0] spr_y[8];
        logic [7:0] xpos_high;
        logic [7:0] ctrl_one;
        logic [7:0] ctrl_two;
        logic [7:0] mem_ptr;
        logic [7:0] spr_mode[5];
        logic [3:0] colour[vrf_pkg::NUM_COLOURS];
        logic [3:0] flags;
        logic [3:0] enables;
        logic [8:0] cmp_line;
        logic       cmp_protect;
        logic [8:0] line_count;
        logic       border;
        logic       bad_row;
        logic [8:0] lines_per_frame;
        vrf_pkg::result_t expected_q[$];
        int         errors;

        function new();
            foreach (spr_x[i])
            begin
                spr_x[i] = '0;
                spr_y[i] = '0;
            end
            foreach (spr_mode[i])
                spr_mode[i] = '0;
            foreach (colour[i])
                colour[i] = '0;
            xpos_high       = '0;
            ctrl_one        = '0;
            ctrl_two        = '0;
            mem_ptr         = '0;
            flags           = '0;
            enables         = '0;
            cmp_line        = '0;
            cmp_protect     = 1'b0;
            line_count      = '0;
            border          = 1'b0;
            bad_row         = 1'b0;
            lines_per_frame = vrf_pkg::LINES_PER_FRAME_RST;
            errors          = 0;
        endfunction

        function logic irq_level();
            return (flags & enables) != 4'h0;
        endfunction

        function void compare_line(int ln);
            if (!cmp_protect && !flags[0] && int'(cmp_line) == ln)
            begin
                flags[0]    = 1'b1;
                cmp_protect = 1'b1;
            end
        endfunction

        function void set_lines_per_frame(logic [8:0] v);
            lines_per_frame = v;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_request(vrf_pkg::action_t act, logic [5:0] addr, logic [7:0] data);
            vrf_pkg::result_t r;
            int      s;
            int      nxt;
            int      top_line;
            int      bottom_line;
            r = '0;
            s = int'(addr >> 1);
            case (act)
                vrf_pkg::ACT_READ:
                begin
                    if (addr <= vrf_pkg::ADDR_SPR_LAST)
                        r.read_data = (s >= SPRITES) ? vrf_pkg::UNMAPPED_DATA :
                                      (addr[0] ? spr_y[s] : spr_x[s][7:0]);
                    else if (addr >= vrf_pkg::ADDR_COL_FIRST && addr <= vrf_pkg::ADDR_COL_LAST)
                        r.read_data = {4'h0, colour[addr - vrf_pkg::ADDR_COL_FIRST]};
                    else
                        case (addr)
                            vrf_pkg::ADDR_XPOS_HIGH: r.read_data = xpos_high;
                            vrf_pkg::ADDR_CTRL_ONE:  r.read_data = ctrl_one;
                            vrf_pkg::ADDR_RASTER:    r.read_data = line_count[7:0];
                            vrf_pkg::ADDR_PEN_X, vrf_pkg::ADDR_PEN_Y,
                            vrf_pkg::ADDR_COLL_SS, vrf_pkg::ADDR_COLL_SB:
                                r.read_data = 8'h00;
                            vrf_pkg::ADDR_SPR_EN:    r.read_data = spr_mode[0];
                            vrf_pkg::ADDR_CTRL_TWO:
                                r.read_data = ctrl_two | vrf_pkg::CTRL_TWO_FILL;
                            vrf_pkg::ADDR_SPR_YEXP:  r.read_data = spr_mode[1];
                            vrf_pkg::ADDR_MEM_PTR:
                                r.read_data = mem_ptr | vrf_pkg::MEM_PTR_FILL;
                            vrf_pkg::ADDR_IRQ_FLAG:
                                r.read_data = {4'h0, flags} | vrf_pkg::IRQ_FLAG_FILL |
                                              (irq_level() ? 8'h80 : 8'h00);
                            vrf_pkg::ADDR_IRQ_EN:
                                r.read_data = {4'h0, enables} | vrf_pkg::IRQ_EN_FILL;
                            vrf_pkg::ADDR_SPR_PRIO:  r.read_data = spr_mode[2];
                            vrf_pkg::ADDR_SPR_MC:    r.read_data = spr_mode[3];
                            vrf_pkg::ADDR_SPR_XEXP:  r.read_data = spr_mode[4];
                            default:                 r.read_data = vrf_pkg::UNMAPPED_DATA;
                        endcase
                end
                vrf_pkg::ACT_WRITE:
                begin
                    if (addr <= vrf_pkg::ADDR_SPR_LAST)
                    begin
                        if (s < SPRITES)
                        begin
                            if (addr[0])
                                spr_y[s] = data;
                            else
                                spr_x[s][7:0] = data;
                        end
                    end
                    else if (addr >= vrf_pkg::ADDR_COL_FIRST && addr <= vrf_pkg::ADDR_COL_LAST)
                        colour[addr - vrf_pkg::ADDR_COL_FIRST] = data[3:0];
                    else
                        case (addr)
                            vrf_pkg::ADDR_XPOS_HIGH:
                            begin
                                for (int i = 0; i < SPRITES; i++)
                                    spr_x[i][8] = data[i];
                                xpos_high = data;
                            end
                            vrf_pkg::ADDR_CTRL_ONE:
                            begin
                                ctrl_one    = data;
                                cmp_line[8] = data[7];
                                compare_line(int'(line_count));
                            end
                            vrf_pkg::ADDR_RASTER:
                            begin
                                cmp_line[7:0] = data;
                                compare_line(int'(line_count));
                            end
                            vrf_pkg::ADDR_SPR_EN:   spr_mode[0] = data;
                            vrf_pkg::ADDR_CTRL_TWO: ctrl_two = data;
                            vrf_pkg::ADDR_SPR_YEXP: spr_mode[1] = data;
                            vrf_pkg::ADDR_MEM_PTR:  mem_ptr = data;
                            vrf_pkg::ADDR_IRQ_FLAG: flags = data[3:0];
                            vrf_pkg::ADDR_IRQ_EN:   enables = data[3:0];
                            vrf_pkg::ADDR_SPR_PRIO: spr_mode[2] = data;
                            vrf_pkg::ADDR_SPR_MC:   spr_mode[3] = data;
                            vrf_pkg::ADDR_SPR_XEXP: spr_mode[4] = data;
                            vrf_pkg::ADDR_COLL_SS:  flags[1] = 1'b0;
                            vrf_pkg::ADDR_COLL_SB:  flags[2] = 1'b0;
                            default: ;
                        endcase
                end
                vrf_pkg::ACT_LINE:
                begin
                    nxt         = int'(line_count) + 1;
                    top_line    = ctrl_one[3] ? int'(vrf_pkg::FIRST_LINE_25)
                                              : int'(vrf_pkg::FIRST_LINE_24);
                    bottom_line = ctrl_one[3] ? int'(vrf_pkg::LAST_LINE_25)
                                              : int'(vrf_pkg::LAST_LINE_24);
                    // protect only survives while the flag is still pending
                    cmp_protect = flags[0];
                    compare_line(nxt);
                    if (nxt == top_line && ctrl_one[4])
                        border = 1'b0;
                    if (nxt == bottom_line)
                        border = 1'b1;
                    bad_row = (nxt >= int'(vrf_pkg::BAD_LINE_LO) &&
                               nxt <= int'(vrf_pkg::BAD_LINE_HI) &&
                               (nxt % 8) == int'(ctrl_one[2:0]));
                    // wrap skips the compare at line zero
                    if (nxt >= int'(lines_per_frame) || nxt > 511)
                        nxt = 0;
                    line_count = nxt[8:0];
                end
                default: ;
            endcase
            r.irq_out         = irq_level();
            r.raster_line     = line_count;
            r.bad_line_flag   = bad_row;
            r.vertical_border = border;
            expected_q.push_back(r);
        endfunction

        function void report_field(string name, logic [8:0] exp_v, logic [8:0] got_v);
            if (exp_v !== got_v)
            begin
                errors++;
                $display("%0t: %s expected %0h actual %0h", $time, name, exp_v, got_v);
            end
        endfunction

        function void check_result(vrf_pkg::result_t got);
            vrf_pkg::result_t exp_r;
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none actual %h", $time, got);
                return;
            end
            exp_r = expected_q.pop_front();
            report_field("read_data", 9'(exp_r.read_data), 9'(got.read_data));
            report_field("irq_out", 9'(exp_r.irq_out), 9'(got.irq_out));
            report_field("raster_line", exp_r.raster_line, got.raster_line);
            report_field("bad_line_flag", 9'(exp_r.bad_line_flag), 9'(got.bad_line_flag));
            report_field("vertical_border", 9'(exp_r.vertical_border),
                         9'(got.vertical_border));
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [8:0]  cfg_wr_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;      // reg_addr[5:0], write_data[13:6], zero fill
    logic [1:0]  s_axis_tuser = '0;      // action[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;           // read_data, irq_out, raster_line, bad_line, border

    raster_regs_scoreboard sb;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          cycles = 0;

    video_register_file_raster_irq i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(vrf_pkg::result_t'(m_axis_tdata[19:0]));
    end

    task automatic send_request(vrf_pkg::action_t act, logic [5:0] addr, logic [7:0] data);
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, data, addr};
        s_axis_tuser  <= act;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_request(act, addr, data);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_lines_per_frame(logic [8:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sb.set_lines_per_frame(v);
    endtask

    // mostly line events with compare, control and flag traffic mixed in
    task automatic random_request();
        int               pick;
        logic [5:0]       addr;
        logic [7:0]       data;
        logic [8:0]       target;
        vrf_pkg::action_t act;
        pick   = int'($urandom_range(99));
        addr   = 6'($urandom_range(63));
        data   = 8'($urandom_range(255));
        target = 9'(int'(sb.line_count) + int'($urandom_range(1, 4)));
        if (pick < 58)
            act = vrf_pkg::ACT_LINE;
        else if (pick < 85)
        begin
            act = vrf_pkg::ACT_WRITE;
            case ($urandom_range(9))
                0:
                begin
                    addr = vrf_pkg::ADDR_RASTER;
                    if ($urandom_range(1))
                        data = target[7:0];
                end
                1:
                begin
                    addr = vrf_pkg::ADDR_CTRL_ONE;
                    if ($urandom_range(3) != 0)
                        data[7] = target[8];
                end
                2: addr = vrf_pkg::ADDR_IRQ_FLAG;
                3: addr = vrf_pkg::ADDR_IRQ_EN;
                4: addr = $urandom_range(1) ? vrf_pkg::ADDR_COLL_SS : vrf_pkg::ADDR_COLL_SB;
                default: ;
            endcase
        end
        else if (pick < 96)
        begin
            act = vrf_pkg::ACT_READ;
            if ($urandom_range(3) == 0)
                addr = $urandom_range(1) ? vrf_pkg::ADDR_IRQ_FLAG : vrf_pkg::ADDR_RASTER;
        end
        else
            act = vrf_pkg::ACT_NONE;
        send_request(act, addr, data);
    endtask

    initial
    begin
        logic [8:0] lpf_list[PHASES];
        sb = new();
        lpf_list[0] = vrf_pkg::LINES_PER_FRAME_RST;
        lpf_list[1] = 9'd511;
        lpf_list[2] = 9'd263;
        lpf_list[3] = 9'd1;
        lpf_list[4] = 9'd60;
        lpf_list[5] = 9'($urandom_range(2, 511));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values, compare hit and protect, flag acks, sprite and colour masks
        send_request(vrf_pkg::ACT_READ,  vrf_pkg::ADDR_IRQ_FLAG,  8'h00);
        send_request(vrf_pkg::ACT_WRITE, vrf_pkg::ADDR_IRQ_EN,    8'hFF);
        send_request(vrf_pkg::ACT_WRITE, vrf_pkg::ADDR_RASTER,    8'h02);
        send_request(vrf_pkg::ACT_LINE,  ADDR_SPR0_X,             8'h00);
        send_request(vrf_pkg::ACT_LINE,  ADDR_TOP,                8'hFF);
        send_request(vrf_pkg::ACT_READ,  vrf_pkg::ADDR_IRQ_FLAG,  8'h00);
        send_request(vrf_pkg::ACT_LINE,  ADDR_SPR0_X,             8'h00);
        send_request(vrf_pkg::ACT_WRITE, vrf_pkg::ADDR_IRQ_FLAG,  8'h00);
        send_request(vrf_pkg::ACT_WRITE, vrf_pkg::ADDR_RASTER,    8'h03);
        send_request(vrf_pkg::ACT_WRITE, vrf_pkg::ADDR_IRQ_FLAG,  8'hFE);
        send_request(vrf_pkg::ACT_WRITE, vrf_pkg::ADDR_COLL_SS,   8'hFF);
        send_request(vrf_pkg::ACT_WRITE, vrf_pkg::ADDR_COLL_SB,   8'h00);
        send_request(vrf_pkg::ACT_READ,  vrf_pkg::ADDR_IRQ_FLAG,  8'h00);
        send_request(vrf_pkg::ACT_WRITE, vrf_pkg::ADDR_XPOS_HIGH, 8'hFF);
        send_request(vrf_pkg::ACT_WRITE, ADDR_SPR0_X,             8'h80);
        send_request(vrf_pkg::ACT_READ,  ADDR_SPR0_X,             8'h00);
        send_request(vrf_pkg::ACT_WRITE, vrf_pkg::ADDR_SPR_LAST,  8'hFF);
        send_request(vrf_pkg::ACT_READ,  vrf_pkg::ADDR_SPR_LAST,  8'h00);
        send_request(vrf_pkg::ACT_WRITE, vrf_pkg::ADDR_COL_LAST,  8'hFF);
        send_request(vrf_pkg::ACT_READ,  vrf_pkg::ADDR_COL_LAST,  8'h00);
        send_request(vrf_pkg::ACT_READ,  ADDR_TOP,                8'h00);
        send_request(vrf_pkg::ACT_WRITE, ADDR_TOP,                8'hAA);
        send_request(vrf_pkg::ACT_NONE,  ADDR_TOP,                8'hFF);
        send_request(vrf_pkg::ACT_READ,  vrf_pkg::ADDR_PEN_X,     8'h00);
        send_request(vrf_pkg::ACT_WRITE, vrf_pkg::ADDR_CTRL_ONE,  8'hFF);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            drain();
            case (phase % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 77;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 77;
                end
                default:
                begin
                    send_idle_pct  = 9;
                    recv_stall_pct = 9;
                end
            endcase
            write_lines_per_frame(lpf_list[phase]);
            repeat (PHASE_ITEMS) random_request();
        end
        drain();

        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
